// ===== hdl/smx_pkg.sv =====
// Shared types and constants for the stack machine executor.
`timescale 1ns / 1ps
package smx_pkg;

  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_PUSH  = 4'd1;
  localparam logic [3:0] OP_POP   = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_MULT  = 4'd5;
  localparam logic [3:0] OP_DIV   = 4'd6;
  localparam logic [3:0] OP_PRINT = 4'd7;
  localparam logic [3:0] OP_PUTS  = 4'd8;
  localparam logic [3:0] OP_RESET = 4'd9;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PRINT = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        [3:0]  opcode;
    logic signed [31:0] operand;
  } smx_in_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
    logic        [1:0]  error;
    logic        [15:0] step_count;
  } smx_out_t;

  // Per-cell move select: take the upper neighbor (push) or the lower one (pop).
  typedef struct packed {
    logic take_prev;
    logic take_next;
  } smx_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DFIN
  } smx_state_e;

endpackage

// ===== hdl/smx_cell.sv =====
// One stack entry cell; shifts toward the top or the bottom of the stack.
`timescale 1ns / 1ps
module smx_cell import smx_pkg::*; (
  input  logic               clk_i,
  input  smx_cell_ctrl_t     ctrl_i,
  input  logic signed [31:0] prev_i,
  input  logic signed [31:0] next_i,
  output logic signed [31:0] data_o
);

  logic signed [31:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_prev) begin
      data_q <= prev_i;
    end else if (ctrl_i.take_next) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== hdl/smx_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`timescale 1ns / 1ps
module smx_div import smx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [16:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [16:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[15:0], quo_q[31]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quo_d  = {quo_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/stack_machine_executor_unit.sv =====
// Top level of the stack machine executor: control, row of stack cells, ALU.
//
// Channel | Direction | Handshake                 | Payload
// --------+-----------+---------------------------+----------------------
// in      | into unit | in_valid_i / in_stall_o   | in_data_i  (smx_in_t)
// out     | from unit | out_valid_o / out_stall_i | out_data_o (smx_out_t)
//
// Most instructions write their result into the output register at the edge
// that accepts the request. MULT registers the 32x32 product before the shift
// and saturation. DIV runs the 32-step restoring divider. Reset empties the
// stack and clears the counter with no clearing pass. A stalled output holds
// the unit: no new request is taken while a finished result cannot move out.
`timescale 1ns / 1ps
module stack_machine_executor_unit import smx_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  smx_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output smx_out_t out_data_o
);

  localparam int FW = $clog2(STACK_DEPTH + 1);

  // Saturate wide signed results into the Q16.16 range.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 34'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 48'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  smx_state_e         state_q, state_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [15:0]        cnt_q, cnt_d;
  smx_out_t           out_q, out_d;
  logic               out_valid_q;
  logic               out_we;
  logic signed [63:0] prod_q;
  logic               prod_we;
  logic               neg_q;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quot;

  logic               accept;
  logic               out_ready;
  logic               shift_dn, shift_up, merge;
  logic signed [31:0] head_val;
  logic signed [31:0] cell_data [STACK_DEPTH];
  smx_cell_ctrl_t     cell_ctrl [STACK_DEPTH];

  logic signed [31:0] opa, opb;
  logic signed [15:0] ntr;
  logic [31:0]        a_mag;
  logic [15:0]        n_mag;
  logic signed [47:0] prod_sh;
  logic signed [32:0] quo_s;
  logic signed [31:0] div_res;
  logic               empty, below_two, full;

  // ---------------------------------------------------------------------------
  // Operand taps: the top of stack sits in cell 0, the entry below it in cell 1.
  // ---------------------------------------------------------------------------
  assign opa = cell_data[1];
  assign opb = cell_data[0];

  // Integer part of the top operand, truncated toward zero.
  assign ntr = opb[31:16] + {15'd0, (opb[31] && (opb[15:0] != 16'd0))};

  assign a_mag = opa[31] ? (32'd0 - opa) : opa;
  assign n_mag = ntr[15] ? (16'd0 - ntr) : ntr;

  // Arithmetic shift right by 16 floors the product.
  assign prod_sh = prod_q[63:16];

  always_comb begin
    quo_s = neg_q ? (33'sd0 - $signed({1'b0, div_quot})) : $signed({1'b0, div_quot});
    // Only most negative by minus one overflows; clamp it to the maximum.
    div_res = (quo_s > 33'(Q_MAX)) ? Q_MAX : quo_s[31:0];
  end

  assign empty     = (fill_q == '0);
  assign below_two = (fill_q < FW'(2));
  assign full      = (fill_q == FW'(STACK_DEPTH));

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !below_two) begin
          if (in_data_i.opcode == OP_MULT) begin
            state_d = ST_MUL;
          end else if (in_data_i.opcode == OP_DIV && ntr != 16'sd0) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_MUL: begin
        if (out_ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        if (out_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath control: stack moves, counter, result and product register writes, divider start.
  // ---------------------------------------------------------------------------
  always_comb begin
    shift_dn  = 1'b0;
    shift_up  = 1'b0;
    merge     = 1'b0;
    head_val  = in_data_i.operand;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    out_we    = 1'b0;
    out_d     = '{kind: KIND_NONE, value: 32'sd0, error: ERR_OK, step_count: cnt_q};
    prod_we   = 1'b0;
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_we = 1'b1;
          cnt_d  = cnt_q + 16'd1;
          unique case (in_data_i.opcode) inside
            OP_PUSH: begin
              if (full) begin
                out_d.error = ERR_OVER;
              end else begin
                shift_dn = 1'b1;
                fill_d   = fill_q + FW'(1);
              end
            end
            OP_POP: begin
              if (empty) begin
                out_d.error = ERR_UNDER;
              end else begin
                shift_up = 1'b1;
                fill_d   = fill_q - FW'(1);
              end
            end
            OP_ADD, OP_SUB: begin
              if (below_two) begin
                out_d.error = ERR_UNDER;
              end else begin
                merge  = 1'b1;
                fill_d = fill_q - FW'(1);
                if (in_data_i.opcode == OP_ADD) begin
                  head_val = sat34(34'(opa) + 34'(opb));
                end else begin
                  head_val = sat34(34'(opa) - $signed({{2{ntr[15]}}, ntr, 16'd0}));
                end
              end
            end
            OP_MULT: begin
              if (below_two) begin
                out_d.error = ERR_UNDER;
              end else begin
                // Hold the result until the product is shifted and clamped.
                out_we  = 1'b0;
                prod_we = 1'b1;
              end
            end
            OP_DIV: begin
              if (below_two) begin
                out_d.error = ERR_UNDER;
              end else if (ntr == 16'sd0) begin
                out_d.error = ERR_DIVZ;
              end else begin
                out_we    = 1'b0;
                div_start = 1'b1;
              end
            end
            OP_PRINT: begin
              if (empty) begin
                out_d.error = ERR_UNDER;
              end else begin
                shift_up    = 1'b1;
                fill_d      = fill_q - FW'(1);
                out_d.kind  = KIND_PRINT;
                out_d.value = opb;
              end
            end
            OP_PUTS: begin
              if (empty) begin
                out_d.error = ERR_UNDER;
              end else begin
                out_d.kind  = KIND_LINE;
                out_d.value = opb;
              end
            end
            OP_RESET: begin
              cnt_d = 16'd1;
            end
            default: begin
            end
          endcase
          // A failed instruction leaves the counter alone.
          if (out_d.error != ERR_OK) begin
            cnt_d = cnt_q;
          end
          out_d.step_count = cnt_d;
        end
      end
      ST_MUL: begin
        if (out_ready) begin
          merge    = 1'b1;
          head_val = sat48(prod_sh);
          fill_d   = fill_q - FW'(1);
          out_we   = 1'b1;
        end
      end
      ST_DIV: begin
      end
      ST_DFIN: begin
        if (out_ready) begin
          merge    = 1'b1;
          head_val = div_res;
          fill_d   = fill_q - FW'(1);
          out_we   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Row of stack cells. Push moves every entry one cell down, pop one cell up;
  // a binary operation drops the result into cell 0 and pulls the rest up
  // from cell 2 onward.
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
    logic signed [31:0] prev_val, next_val;

    if (gi == 0) begin : g_head
      assign prev_val = head_val;
      assign cell_ctrl[gi].take_prev = shift_dn || merge;
      assign cell_ctrl[gi].take_next = shift_up;
    end else begin : g_body
      assign prev_val = cell_data[gi-1];
      assign cell_ctrl[gi].take_prev = shift_dn;
      assign cell_ctrl[gi].take_next = shift_up || merge;
    end

    if (gi == STACK_DEPTH - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_link
      assign next_val = cell_data[gi+1];
    end

    smx_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[gi]),
      .prev_i (prev_val),
      .next_i (next_val),
      .data_o (cell_data[gi])
    );
  end

  // Divider works on magnitudes; the sign is reapplied at the end.
  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_mag),
    .divisor_i  (n_mag),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      if (out_we) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_q <= out_d;
    end
    if (prod_we) begin
      prod_q <= opa * opb;
    end
    if (div_start) begin
      neg_q <= opa[31] ^ ntr[15];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  a_err_no_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error != ERR_OK) |-> (out_q.kind == KIND_NONE))
    else $error("failed instruction carries output");

  a_div_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == ST_DIV))
    else $error("divider started outside divide sequence");

  a_busy_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV || state_q == ST_DFIN) |-> in_stall_o)
    else $error("request taken while an instruction is in flight");

endmodule
